FILE: sv/faa_pkg.sv
package faa_pkg;

    localparam int MAX_PIXELS_DEF = 1048576;
    localparam int MAX_FRAMES_DEF = 256;

    localparam int VAL_W  = 16;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = 24;

    // configuration registers
    localparam int PPF_W      = 21;
    localparam int FTA_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] REG_PIXELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'b1;

    localparam logic [PPF_W-1:0] PPF_RESET = 21'd1048576;
    localparam logic [FTA_W-1:0] FTA_RESET = 9'd1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // bit-serial divider step counter
    localparam int DCNT_W = 5;

    localparam logic [VAL_W-1:0]  AVG_MAX   = 16'hFFFF;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic first;
        logic wr;
        logic emit;
        logic end_pix;
    } faa_flags_t;

endpackage

FILE: sv/faa_fifo.sv
module faa_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);
    import faa_pkg::*;

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/faa_front.sv
module faa_front #(
    parameter int MAX_PIXELS = faa_pkg::MAX_PIXELS_DEF,
    parameter int MAX_FRAMES = faa_pkg::MAX_FRAMES_DEF,
    localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int DIV_W = $clog2(MAX_FRAMES + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [faa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [faa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [faa_pkg::VAL_W-1:0]      pixel_value,
    input  logic                           q_full,
    output logic                           q_push,
    output faa_pkg::faa_flags_t            cmd_flags,
    output logic [PIX_W-1:0]               cmd_addr,
    output logic [DIV_W-1:0]               cmd_divisor,
    output logic [faa_pkg::VAL_W-1:0]      cmd_value
);
    import faa_pkg::*;

    localparam int FRM_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int PIX_BITS = $clog2(MAX_PIXELS + 1);
    localparam int PCMP_W   = (PIX_BITS > PPF_W) ? PIX_BITS : PPF_W;
    localparam int FRM_BITS = $clog2(MAX_FRAMES + 1);
    localparam int FCMP_W   = (FRM_BITS > FTA_W) ? FRM_BITS : FTA_W;

    logic [PPF_W-1:0]  ppf_reg;
    logic [FTA_W-1:0]  fta_reg;
    logic [PIX_W-1:0]  pix_pos_reg;
    logic [PIX_W-1:0]  pix_pos_next;
    logic [FRM_W-1:0]  frm_pos_reg;
    logic [FRM_W-1:0]  frm_pos_next;

    logic [PCMP_W-1:0] ppf_ext;
    logic [PCMP_W-1:0] eff_pix;
    logic [PCMP_W-1:0] last_pix;
    logic [FCMP_W-1:0] fta_ext;
    logic [FCMP_W-1:0] eff_frm;
    logic [FCMP_W-1:0] last_frm;
    logic              end_pix;
    logic              end_frame;
    logic              in_range;
    logic              accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppf_reg <= PPF_RESET;
            fta_reg <= FTA_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PIXELS: ppf_reg <= cfg_data[PPF_W-1:0];
                REG_FRAMES: fta_reg <= cfg_data[FTA_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversized counts clamp to the storage limits
    always_comb
    begin
        ppf_ext = PCMP_W'(ppf_reg);
        if (ppf_ext == '0)
        begin
            eff_pix = PCMP_W'(1);
        end
        else if (ppf_ext > PCMP_W'(MAX_PIXELS))
        begin
            eff_pix = PCMP_W'(MAX_PIXELS);
        end
        else
        begin
            eff_pix = ppf_ext;
        end
        last_pix = eff_pix - PCMP_W'(1);

        fta_ext = FCMP_W'(fta_reg);
        if (fta_ext == '0)
        begin
            eff_frm = FCMP_W'(1);
        end
        else if (fta_ext > FCMP_W'(MAX_FRAMES))
        begin
            eff_frm = FCMP_W'(MAX_FRAMES);
        end
        else
        begin
            eff_frm = fta_ext;
        end
        last_frm = eff_frm - FCMP_W'(1);
    end

    // at or past the last index counts as the last one
    assign end_pix   = (PCMP_W'(pix_pos_reg) >= last_pix);
    assign end_frame = (FCMP_W'(frm_pos_reg) >= last_frm);
    assign in_range  = (PCMP_W'(pix_pos_reg) < PCMP_W'(MAX_PIXELS));

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign q_push   = accept;

    assign cmd_flags.first   = (frm_pos_reg == '0) || !in_range;
    assign cmd_flags.wr      = !end_frame && in_range;
    assign cmd_flags.emit    = end_frame;
    assign cmd_flags.end_pix = end_pix;
    assign cmd_addr          = pix_pos_reg;
    assign cmd_divisor       = DIV_W'(frm_pos_reg) + DIV_W'(1);
    assign cmd_value         = pixel_value;

    always_comb
    begin
        pix_pos_next = pix_pos_reg + PIX_W'(1);
        frm_pos_next = frm_pos_reg;
        if (end_pix)
        begin
            pix_pos_next = '0;
            frm_pos_next = end_frame ? '0 : frm_pos_reg + FRM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_pos_reg <= '0;
            frm_pos_reg <= '0;
        end
        else if (accept)
        begin
            pix_pos_reg <= pix_pos_next;
            frm_pos_reg <= frm_pos_next;
        end
    end

endmodule

FILE: sv/faa_divider.sv
module faa_divider #(
    parameter int DIV_W = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [faa_pkg::SUM_W-1:0] dividend,
    input  logic [DIV_W-1:0]          divisor,
    output logic                      done,
    output logic [faa_pkg::SUM_W-1:0] quotient
);
    import faa_pkg::*;

    logic                active_reg;
    logic                done_reg;
    logic [DCNT_W-1:0]   count_reg;
    logic [DIV_W-1:0]    divisor_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    rem_next;
    logic [SUM_W-1:0]    quo_reg;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic                q_bit;

    // restoring division, one quotient bit per cycle, msb first
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign q_bit = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        rem_next = q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                count_reg  <= DCNT_W'(SUM_W - 1);
            end
            else if (active_reg)
            begin
                count_reg <= count_reg - DCNT_W'(1);
                if (count_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= dividend;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SUM_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/faa_back.sv
module faa_back #(
    parameter int MAX_PIXELS = faa_pkg::MAX_PIXELS_DEF,
    parameter int MAX_FRAMES = faa_pkg::MAX_FRAMES_DEF,
    localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int DIV_W = $clog2(MAX_FRAMES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    output logic                       q_pop,
    input  faa_pkg::faa_flags_t        cmd_flags,
    input  logic [PIX_W-1:0]           cmd_addr,
    input  logic [DIV_W-1:0]           cmd_divisor,
    input  logic [faa_pkg::VAL_W-1:0]  cmd_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [faa_pkg::VAL_W-1:0]  average_value,
    output logic [faa_pkg::BYTE_W-1:0] upper_byte,
    output logic [faa_pkg::BYTE_W-1:0] lower_byte,
    output logic                       frame_end
);
    import faa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [SUM_W-1:0] sum_mem [MAX_PIXELS];

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    faa_flags_t        flags_reg;
    logic [PIX_W-1:0]  addr_reg;
    logic [DIV_W-1:0]  divisor_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [SUM_W-1:0]  rd_data_reg;
    logic [SUM_W-1:0]  sum;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  quotient;
    logic [VAL_W-1:0]  avg;
    logic              out_free;
    logic              load_out;

    logic              out_valid_reg;
    logic [VAL_W-1:0]  avg_reg;
    logic              frame_end_reg;

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign sum       = flags_reg.first ? SUM_W'(value_reg) : rd_data_reg + SUM_W'(value_reg);
    assign div_start = (state_reg == S_SUM) && flags_reg.emit;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == S_OUT) && out_free;

    // averages that no longer fit in 16 bits saturate
    assign avg = (|quotient[SUM_W-1:VAL_W]) ? AVG_MAX : quotient[VAL_W-1:0];

    faa_divider #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = flags_reg.emit ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            flags_reg   <= cmd_flags;
            addr_reg    <= cmd_addr;
            divisor_reg <= cmd_divisor;
            value_reg   <= cmd_value;
        end
        if (load_out)
        begin
            avg_reg       <= avg;
            frame_end_reg <= flags_reg.end_pix;
        end
    end

    // sum store: one read and one write port, read data registered
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_data_reg <= sum_mem[cmd_addr];
        end
        if ((state_reg == S_SUM) && flags_reg.wr)
        begin
            sum_mem[addr_reg] <= sum;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average_value = avg_reg;
    assign upper_byte    = avg_reg[VAL_W-1:BYTE_W];
    assign lower_byte    = avg_reg[BYTE_W-1:0] & BYTE_MASK;
    assign frame_end     = frame_end_reg;

endmodule

FILE: sv/frame_average_accumulator.sv
// Pixel-by-pixel average of a run of 16-bit grayscale frames. Pixels enter in raster order,
// one word per accepted input; a word is returned only during the last frame of a run, carrying
// floor(sum / frames accumulated) saturated to 16 bits, its two bytes and a mark on the last
// pixel of the frame. The front takes a pixel whenever the queue has room and queues up to four
// ahead; the back pops one pixel at a time, does the read-modify-write of the sum store and, in
// the last frame, waits on the bit-serial divider and the receiver before it pops the next one.
// Register writes take effect at once and belong between runs or while the block is idle.
module frame_average_accumulator #(
    parameter int MAX_PIXELS = faa_pkg::MAX_PIXELS_DEF,
    parameter int MAX_FRAMES = faa_pkg::MAX_FRAMES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [faa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [faa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [faa_pkg::VAL_W-1:0]      pixel_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [faa_pkg::VAL_W-1:0]      average_value,
    output logic [faa_pkg::BYTE_W-1:0]     upper_byte,
    output logic [faa_pkg::BYTE_W-1:0]     lower_byte,
    output logic                           frame_end
);
    import faa_pkg::*;

    localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int DIV_W = $clog2(MAX_FRAMES + 1);
    localparam int FLG_W = $bits(faa_flags_t);
    localparam int Q_W   = FLG_W + PIX_W + DIV_W + VAL_W;

    faa_flags_t       f_flags;
    logic [PIX_W-1:0] f_addr;
    logic [DIV_W-1:0] f_divisor;
    logic [VAL_W-1:0] f_value;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [Q_W-1:0]   q_head;
    faa_flags_t       b_flags;
    logic [PIX_W-1:0] b_addr;
    logic [DIV_W-1:0] b_divisor;
    logic [VAL_W-1:0] b_value;

    faa_front #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .q_full      (q_full),
        .q_push      (q_push),
        .cmd_flags   (f_flags),
        .cmd_addr    (f_addr),
        .cmd_divisor (f_divisor),
        .cmd_value   (f_value)
    );

    faa_fifo #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_flags, f_addr, f_divisor, f_value}),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {b_flags, b_addr, b_divisor, b_value} = q_head;

    faa_back #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .cmd_flags     (b_flags),
        .cmd_addr      (b_addr),
        .cmd_divisor   (b_divisor),
        .cmd_value     (b_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average_value (average_value),
        .upper_byte    (upper_byte),
        .lower_byte    (lower_byte),
        .frame_end     (frame_end)
    );

endmodule

FILE: bench/frame_average_accumulator_tb.sv
module frame_average_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import faa_pkg::*;

    localparam int PIXEL_LIMIT   = MAX_PIXELS_DEF;
    localparam int FRAME_LIMIT   = MAX_FRAMES_DEF;
    localparam int IDLE_PERCENT  = 27;
    localparam int DRAIN_CYCLES  = 40;
    localparam int END_WAIT      = 200;
    localparam int RECEIVER_HOLD = 400;
    localparam int ITEM_TARGET   = 850;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_RUN      = 3;
    localparam int LONG_RUN      = 6;
    localparam int STEADY_FIRST  = 12;
    localparam int STEADY_LAST   = 19;

    typedef struct packed {
        logic [VAL_W-1:0]  average;
        logic [BYTE_W-1:0] upper;
        logic [BYTE_W-1:0] lower;
        logic              frame_end;
    } average_word_t;

    // running per-pixel sums and the averages they should produce
    class average_scoreboard;
        bit [SUM_W-1:0]    pixel_sums [PIXEL_LIMIT];
        int unsigned       pixel_pos;
        int unsigned       frame_pos;
        logic [PPF_W-1:0]  pixels_reg;
        logic [FTA_W-1:0]  frames_reg;
        average_word_t     expected_words [$];
        int unsigned       errors;

        function new();
            pixel_pos  = 0;
            frame_pos  = 0;
            pixels_reg = PPF_RESET;
            frames_reg = FTA_RESET;
            errors     = 0;
        endfunction

        function int unsigned active_pixels();
            if (pixels_reg == 0)
                return 1;
            if (pixels_reg > PIXEL_LIMIT)
                return PIXEL_LIMIT;
            return pixels_reg;
        endfunction

        function int unsigned active_frames();
            if (frames_reg == 0)
                return 1;
            if (frames_reg > FRAME_LIMIT)
                return FRAME_LIMIT;
            return frames_reg;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_PIXELS)
                pixels_reg = data[PPF_W-1:0];
            else if (index == REG_FRAMES)
                frames_reg = data[FTA_W-1:0];
        endfunction

        function void take_pixel(logic [VAL_W-1:0] value);
            int unsigned    last_pix;
            int unsigned    last_frame;
            int unsigned    p;
            bit             in_range;
            bit             pix_done;
            bit             frame_done;
            bit [SUM_W-1:0] sum;
            bit [31:0]      quotient;
            average_word_t  word;
            last_pix   = active_pixels() - 1;
            last_frame = active_frames() - 1;
            p          = pixel_pos;
            in_range   = p < PIXEL_LIMIT;
            pix_done   = p >= last_pix;
            frame_done = frame_pos >= last_frame;
            if (frame_pos == 0 || !in_range)
                sum = value;
            else
                sum = pixel_sums[p] + value;
            if (frame_done)
            begin
                quotient = sum / (frame_pos + 1);
                if (quotient > AVG_MAX)
                    quotient = AVG_MAX;
                word.average   = quotient[15:0];
                word.upper     = quotient[15:8];
                word.lower     = quotient[7:0];
                word.frame_end = pix_done;
                expected_words = {expected_words, word};
            end
            else if (in_range)
            begin
                pixel_sums[p] = sum;
            end
            if (pix_done)
            begin
                pixel_pos = 0;
                frame_pos = frame_done ? 0 : frame_pos + 1;
            end
            else
            begin
                pixel_pos = p + 1;
            end
        endfunction

        function void compare_field(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %h got %h", $time, field, want, got);
            end
        endfunction

        function void check_average(logic [VAL_W-1:0] average, logic [BYTE_W-1:0] upper,
                                    logic [BYTE_W-1:0] lower, logic frame_end);
            average_word_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, average %h frame_end %b", $time, average,
                         frame_end);
                return;
            end
            want = expected_words.pop_front();
            compare_field("average_value", want.average, average);
            compare_field("upper_byte", VAL_W'(want.upper), VAL_W'(upper));
            compare_field("lower_byte", VAL_W'(want.lower), VAL_W'(lower));
            compare_field("frame_end", VAL_W'(want.frame_end), VAL_W'(frame_end));
        endfunction

        // pixels still to come before both positions return to zero
        function int unsigned items_to_run_end();
            int unsigned last_pix;
            int unsigned last_frame;
            int unsigned this_frame;
            int unsigned frames_left;
            last_pix    = active_pixels() - 1;
            last_frame  = active_frames() - 1;
            this_frame  = (pixel_pos >= last_pix) ? 1 : last_pix - pixel_pos + 1;
            frames_left = (frame_pos >= last_frame) ? 0 : last_frame - frame_pos;
            return this_frame + frames_left * active_pixels();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PIXELS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [VAL_W-1:0]      pixel_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [VAL_W-1:0]      average_value;
    logic [BYTE_W-1:0]     upper_byte;
    logic [BYTE_W-1:0]     lower_byte;
    logic                  frame_end;

    bit                    steady = 1'b0;
    bit                    hold_request = 1'b0;
    int unsigned           items_sent = 0;
    int unsigned           cycles_run;
    average_scoreboard     book = new();

    frame_average_accumulator #(
        .MAX_PIXELS (PIXEL_LIMIT),
        .MAX_FRAMES (FRAME_LIMIT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average_value (average_value),
        .upper_byte    (upper_byte),
        .lower_byte    (lower_byte),
        .frame_end     (frame_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                book.set_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                book.take_pixel(pixel_value);
            if (out_valid && !out_stall)
                book.check_average(average_value, upper_byte, lower_byte, frame_end);
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = RECEIVER_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    initial
    begin
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("frame_average_accumulator_tb: errors");
        $finish;
    end

    function automatic logic [VAL_W-1:0] random_pixel();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        if (roll < 30)
            return VAL_W'($urandom_range(255));
        return VAL_W'($urandom_range(65535));
    endfunction

    task automatic send_pixel(input logic [VAL_W-1:0] value);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= value;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count)
            send_pixel(random_pixel());
    endtask

    // stop sending, let every average come back, then let the back end empty out
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pick_run_setting(input int unsigned run_no);
        logic [CFG_DATA_W-1:0] pixels;
        logic [CFG_DATA_W-1:0] frames;
        int unsigned           roll;
        roll = $urandom_range(99);
        if (roll < 70)
            pixels = CFG_DATA_W'($urandom_range(8, 1));
        else if (roll < 90)
            pixels = CFG_DATA_W'($urandom_range(48, 9));
        else
            pixels = '0;
        roll = $urandom_range(99);
        if (roll < 60)
        begin
            frames = CFG_DATA_W'($urandom_range(4, 1));
        end
        else if (roll < 80)
        begin
            frames = CFG_DATA_W'($urandom_range(12, 5));
        end
        else if (roll < 90)
        begin
            frames = '0;
        end
        else
        begin
            // junk above the register width must be dropped
            frames = CFG_DATA_W'($urandom);
            frames[FTA_W-1:0] = FTA_W'($urandom_range(4, 1));
        end
        if (run_no == LONG_RUN)
        begin
            pixels = CFG_DATA_W'(1);
            frames = CFG_DATA_W'(FRAME_LIMIT);
        end
        write_register(REG_PIXELS, pixels);
        write_register(REG_FRAMES, frames);
    endtask

    // change a register part way through a run without exposing a never-written sum;
    // a run still in its only frame has stored nothing, so its frame count stays
    task automatic shift_setting_mid_run();
        if ($urandom_range(1) && (book.frame_pos != 0 || book.active_frames() > 1))
            write_register(REG_FRAMES, CFG_DATA_W'($urandom_range(6)));
        else if (book.frame_pos == 0)
            write_register(REG_PIXELS, CFG_DATA_W'($urandom_range(48)));
        else
            write_register(REG_PIXELS, CFG_DATA_W'($urandom_range(book.active_pixels())));
    endtask

    task automatic run_random_sets();
        int unsigned run_no;
        int unsigned remaining;
        run_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            steady = (run_no >= STEADY_FIRST && run_no < STEADY_LAST);
            wait_for_quiet();
            if (run_no == HOLD_RUN)
            begin
                // receiver sits still while pixels keep coming, so the queue backs up
                write_register(REG_PIXELS, CFG_DATA_W'(6));
                write_register(REG_FRAMES, CFG_DATA_W'(1));
                steady       = 1'b1;
                hold_request = 1'b1;
                send_pixels(36);
                steady = 1'b0;
            end
            else
            begin
                pick_run_setting(run_no);
                remaining = book.items_to_run_end();
                if (remaining > 2 && $urandom_range(99) < 20)
                begin
                    send_pixels($urandom_range(remaining - 1, 1));
                    wait_for_quiet();
                    shift_setting_mid_run();
                    remaining = book.items_to_run_end();
                end
                send_pixels(remaining);
            end
            run_no++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: one huge frame per run, every pixel averaged over one frame
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        wait_for_quiet();
        // current position is already past the new last pixel
        write_register(REG_PIXELS, CFG_DATA_W'(2));
        send_pixel(16'h8001);
        wait_for_quiet();

        // zero counts behave as one
        write_register(REG_PIXELS, '0);
        write_register(REG_FRAMES, '0);
        send_pixel(16'hFFFF);
        send_pixel(16'h00FF);
        wait_for_quiet();

        write_register(REG_PIXELS, CFG_DATA_W'(3));
        write_register(REG_FRAMES, CFG_DATA_W'(2));
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0001);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h0002);
        wait_for_quiet();

        // oversized counts clamp, then both shrink part way through the run
        write_register(REG_PIXELS, '1);
        write_register(REG_FRAMES, CFG_DATA_W'(9'h1FF));
        send_pixel(16'hA5A5);
        send_pixel(16'h5A5A);
        send_pixel(16'hFFFE);
        wait_for_quiet();
        write_register(REG_PIXELS, CFG_DATA_W'(1));
        send_pixel(16'h1234);
        wait_for_quiet();
        write_register(REG_FRAMES, CFG_DATA_W'(2));
        send_pixel(16'hFEDC);
        wait_for_quiet();

        // leave large sums behind, then pick one up later with a small divisor
        write_register(REG_PIXELS, CFG_DATA_W'(2));
        write_register(REG_FRAMES, CFG_DATA_W'(4));
        repeat (8)
            send_pixel(16'hFFFF);
        wait_for_quiet();
        write_register(REG_PIXELS, CFG_DATA_W'(1));
        write_register(REG_FRAMES, CFG_DATA_W'(3));
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        wait_for_quiet();
        write_register(REG_PIXELS, CFG_DATA_W'(2));
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);

        run_random_sets();

        wait_for_quiet();
        repeat (END_WAIT)
            @(posedge clk);
        if (book.errors == 0 && book.expected_words.size() == 0)
            $display("frame_average_accumulator_tb: clean");
        else
            $display("frame_average_accumulator_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/faa_pkg.sv
sv/faa_fifo.sv
sv/faa_front.sv
sv/faa_divider.sv
sv/faa_back.sv
sv/frame_average_accumulator.sv
bench/frame_average_accumulator_tb.sv
